/* hw/rtl/bqf_pkg.sv */
// Shared constants, codes and types for the biquad IIR filter.
package bqf_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 20;
    localparam int COEF_BITS          = 24;
    localparam int ACC_BITS           = 40;
    localparam int NUM_COEFS          = 5;
    localparam int ADDR_BITS          = 5;
    localparam int APB_DATA_BITS      = 32;
    localparam int IDX_BITS           = ADDR_BITS - 2;

    localparam logic [IDX_BITS-1:0] REG_B0 = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_B1 = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_B2 = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_A1 = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_A2 = 3'd4;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_MB0  = 3'd1;
    localparam logic [2:0] OP_A0   = 3'd2;
    localparam logic [2:0] OP_Y    = 3'd3;
    localparam logic [2:0] OP_MA1  = 3'd4;
    localparam logic [2:0] OP_MA2  = 3'd5;
    localparam logic [2:0] OP_DONE = 3'd6;

    typedef logic signed [COEF_BITS-1:0] coef_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coefs_t;

    typedef struct packed {
        logic       load_x;
        logic [2:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

/* hw/rtl/bqf_regs.sv */
// Coefficient register file with APB-style access and delay-line clear request.
module bqf_regs #(
    parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bqf_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [bqf_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [bqf_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output bqf_pkg::coefs_t                     coefs,
    output logic                                clr_delay
);
    import bqf_pkg::*;

    localparam coef_t COEF_ONE = (COEF_FRAC_BITS >= COEF_BITS - 1) ?
                                 {1'b0, {(COEF_BITS-1){1'b1}}} :
                                 COEF_BITS'(1) << COEF_FRAC_BITS;

    coefs_t              coefs_reg, coefs_next;
    logic                clr_hit;
    logic                wr_en;
    logic [IDX_BITS-1:0] idx;
    coef_t               wval;
    coef_t               rval;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_BITS-1:2];
    assign wval   = coef_t'(pwdata[COEF_BITS-1:0]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        coefs_next = coefs_reg;
        clr_hit    = 1'b0;
        if (wr_en) begin
            clr_hit = 1'b1;
            case (idx)
                REG_B0:  coefs_next.b0 = wval;
                REG_B1:  coefs_next.b1 = wval;
                REG_B2:  coefs_next.b2 = wval;
                REG_A1:  coefs_next.a1 = wval;
                REG_A2:  coefs_next.a2 = wval;
                default: clr_hit = 1'b0;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_B0:  rval = coefs_reg.b0;
            REG_B1:  rval = coefs_reg.b1;
            REG_B2:  rval = coefs_reg.b2;
            REG_A1:  rval = coefs_reg.a1;
            REG_A2:  rval = coefs_reg.a2;
            default: rval = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_BITS-COEF_BITS){rval[COEF_BITS-1]}}, rval};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg.b0 <= COEF_ONE;
            coefs_reg.b1 <= '0;
            coefs_reg.b2 <= '0;
            coefs_reg.a1 <= '0;
            coefs_reg.a2 <= '0;
        end else begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs     = coefs_reg;
    assign clr_delay = clr_hit;

endmodule

/* hw/rtl/bqf_ctrl.sv */
// Sequencer that steps the shared multiplier through the six operations of one sample.
module bqf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bqf_pkg::dp_stat_t  stat,
    output bqf_pkg::dp_cmd_t   cmd
);
    import bqf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MB0  = 3'd1;
    localparam logic [2:0] ST_A0   = 3'd2;
    localparam logic [2:0] ST_Y    = 3'd3;
    localparam logic [2:0] ST_MA1  = 3'd4;
    localparam logic [2:0] ST_MA2  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.load_x = 1'b0;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_x = 1'b1;
                    state_next = ST_MB0;
                end
            end
            ST_MB0: begin
                cmd.op     = OP_MB0;
                state_next = ST_A0;
            end
            ST_A0: begin
                cmd.op     = OP_A0;
                state_next = ST_Y;
            end
            ST_Y: begin
                cmd.op     = OP_Y;
                state_next = ST_MA1;
            end
            ST_MA1: begin
                cmd.op     = OP_MA1;
                state_next = ST_MA2;
            end
            ST_MA2: begin
                cmd.op     = OP_MA2;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = OP_DONE;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/bqf_datapath.sv */
// Shared multiplier, accumulators, delay registers and output register of the filter.
module bqf_datapath #(
    parameter int SAMPLE_WIDTH   = bqf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bqf_pkg::dp_cmd_t               cmd,
    output bqf_pkg::dp_stat_t              stat,
    input  bqf_pkg::coefs_t                coefs,
    input  logic                           clr_delay,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample
);
    import bqf_pkg::*;

    localparam int PW   = COEF_BITS + SAMPLE_WIDTH;
    localparam int SUMW = ((PW > ACC_BITS) ? PW : ACC_BITS) + 2;
    localparam int AW   = ACC_BITS + 1;
    localparam logic signed [AW-1:0] RND_HALF = AW'(1) << (COEF_FRAC_BITS - 1);

    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [SUMW-1:0] v);
        logic ovf;
        ovf = (v[SUMW-1:ACC_BITS-1] != {(SUMW-ACC_BITS+1){v[SUMW-1]}});
        if (ovf) begin
            return {v[SUMW-1], {(ACC_BITS-1){~v[SUMW-1]}}};
        end
        return v[ACC_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_smp(input logic signed [AW-1:0] v);
        logic ovf;
        ovf = (v[AW-1:SAMPLE_WIDTH-1] != {(AW-SAMPLE_WIDTH+1){v[AW-1]}});
        if (ovf) begin
            return {v[AW-1], {(SAMPLE_WIDTH-1){~v[AW-1]}}};
        end
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    logic signed [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic signed [SAMPLE_WIDTH-1:0] y_reg, y_next;
    logic signed [PW-1:0]           prod_reg, prod_next;
    logic signed [SUMW-1:0]         sum_reg, sum_next;
    logic signed [SUMW-1:0]         sum2_reg, sum2_next;
    logic signed [ACC_BITS-1:0]     d1_reg, d1_next;
    logic signed [ACC_BITS-1:0]     d2_reg, d2_next;
    logic signed [SAMPLE_WIDTH-1:0] out_reg, out_next;
    logic                           mv_reg, mv_next;

    coef_t                          mul_a;
    logic signed [SAMPLE_WIDTH-1:0] mul_b;
    logic signed [SUMW-1:0]         prod_ext;
    logic signed [SUMW-1:0]         d1_ext;
    logic signed [SUMW-1:0]         d2_ext;
    logic signed [ACC_BITS-1:0]     acc_sat;
    logic signed [AW-1:0]           rnd;
    logic signed [AW-1:0]           quo;

    assign prod_ext = SUMW'(prod_reg);
    assign d1_ext   = SUMW'(d1_reg);
    assign d2_ext   = SUMW'(d2_reg);
    assign acc_sat  = sat_acc(sum_reg);
    assign rnd      = $signed({acc_sat[ACC_BITS-1], acc_sat}) + RND_HALF;
    assign quo      = rnd >>> COEF_FRAC_BITS;

    assign stat.out_free = !mv_reg || m_ready;

    always_comb begin
        case (cmd.op)
            OP_MB0:  begin mul_a = coefs.b0; mul_b = x_reg; end
            OP_A0:   begin mul_a = coefs.b1; mul_b = x_reg; end
            OP_Y:    begin mul_a = coefs.b2; mul_b = x_reg; end
            OP_MA1:  begin mul_a = coefs.a1; mul_b = y_reg; end
            OP_MA2:  begin mul_a = coefs.a2; mul_b = y_reg; end
            default: begin mul_a = coefs.b0; mul_b = x_reg; end
        endcase
    end

    always_comb begin
        x_next    = cmd.load_x ? s_sample : x_reg;
        y_next    = y_reg;
        prod_next = ((cmd.op == OP_NONE) || (cmd.op == OP_DONE)) ? prod_reg :
                    PW'(mul_a) * PW'(mul_b);
        sum_next  = sum_reg;
        sum2_next = sum2_reg;
        d1_next   = d1_reg;
        d2_next   = d2_reg;
        out_next  = out_reg;
        mv_next   = mv_reg && !m_ready;
        case (cmd.op)
            OP_A0: begin
                sum_next = prod_ext + d1_ext;
            end
            OP_Y: begin
                y_next   = sat_smp(quo);
                sum_next = prod_ext + d2_ext;
            end
            OP_MA1: begin
                sum2_next = prod_ext;
            end
            OP_MA2: begin
                sum_next = sum_reg - prod_ext;
            end
            OP_DONE: begin
                d1_next  = sat_acc(sum_reg);
                d2_next  = sat_acc(sum2_reg - prod_ext);
                out_next = y_reg;
                mv_next  = 1'b1;
            end
            default: begin
            end
        endcase
        if (clr_delay) begin
            d1_next = '0;
            d2_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        sum2_reg <= sum2_next;
        out_reg  <= out_next;
    end

    assign m_valid  = mv_reg;
    assign m_sample = out_reg;

endmodule

/* hw/rtl/biquad_iir_filter_top.sv */
// Top level of the transposed direct form II biquad filter with stream and APB ports.
//
//   Port group   Direction   Transfer content
//   s_*          in          one input sample per transfer
//   m_*          out         one filtered sample per transfer
//   p*           in/out      coefficient register reads and writes
//
// After its input transfer a sample runs through five multiply steps and a done
// step, which loads its result into the output register; no new input transfer
// is taken until the sequencer is idle again, so the single shared 24-bit by
// sample-width multiplier, used once in each of the five steps, serves one sample.
// Reset is synchronous and active low; it loads unity passthrough coefficients
// and clears both delay accumulators. A coefficient write also clears them.
// The output register holds a finished result while the next sample is taken;
// a sample completes only once that register is free.
module biquad_iir_filter_top #(
    parameter int SAMPLE_WIDTH   = bqf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [SAMPLE_WIDTH-1:0] sample_in, rest zero
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [SAMPLE_WIDTH-1:0] sample_out, rest zero
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bqf_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [bqf_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [bqf_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import bqf_pkg::*;

    localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

    coefs_t                         coefs;
    logic                           clr_delay;
    dp_cmd_t                        cmd;
    dp_stat_t                       stat;
    logic signed [SAMPLE_WIDTH-1:0] m_sample;

    bqf_regs #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .coefs    (coefs),
        .clr_delay(clr_delay)
    );

    bqf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bqf_datapath #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .coefs    (coefs),
        .clr_delay(clr_delay),
        .s_sample ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_sample (m_sample)
    );

    assign m_tdata = DW'($unsigned(m_sample));

endmodule

/* dv/biquad_output_checker.sv */
`timescale 1ns / 1ps
// Watches the biquad filter's ports, predicts every output sample and compares it.
module biquad_output_checker #(
    parameter int SAMPLE_WIDTH   = bqf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF,
    parameter int DATA_W         = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [DATA_W-1:0]                 s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [DATA_W-1:0]                 m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [bqf_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [bqf_pkg::APB_DATA_BITS-1:0] pwdata,
    output int                                mismatch_count,
    output int                                outstanding,
    output int                                samples_checked
);

    longint                     coef_val [bqf_pkg::NUM_COEFS];
    longint                     delay_one;
    longint                     delay_two;
    logic [SAMPLE_WIDTH-1:0]    expected_samples [$];

    function automatic longint clamp_to(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // The feedback terms use the rounded and saturated output sample.
    function automatic longint filter_sample(longint x);
        longint acc;
        longint y;
        acc = clamp_to(coef_val[bqf_pkg::REG_B0] * x + delay_one, bqf_pkg::ACC_BITS);
        y = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        y = clamp_to(y, SAMPLE_WIDTH);
        delay_one = clamp_to(coef_val[bqf_pkg::REG_B1] * x - coef_val[bqf_pkg::REG_A1] * y
                             + delay_two, bqf_pkg::ACC_BITS);
        delay_two = clamp_to(coef_val[bqf_pkg::REG_B2] * x - coef_val[bqf_pkg::REG_A2] * y,
                             bqf_pkg::ACC_BITS);
        return y;
    endfunction

    always @(posedge aclk) begin
        logic [bqf_pkg::IDX_BITS-1:0] idx;
        logic [SAMPLE_WIDTH-1:0]      want;
        logic [SAMPLE_WIDTH-1:0]      got;
        if (!aresetn) begin
            coef_val[bqf_pkg::REG_B0] = clamp_to(longint'(1) <<< COEF_FRAC_BITS,
                                                 bqf_pkg::COEF_BITS);
            coef_val[bqf_pkg::REG_B1] = 0;
            coef_val[bqf_pkg::REG_B2] = 0;
            coef_val[bqf_pkg::REG_A1] = 0;
            coef_val[bqf_pkg::REG_A2] = 0;
            delay_one = 0;
            delay_two = 0;
            expected_samples.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = paddr[bqf_pkg::ADDR_BITS-1:2];
                if (idx < bqf_pkg::NUM_COEFS) begin
                    coef_val[idx] = longint'($signed(pwdata[bqf_pkg::COEF_BITS-1:0]));
                    delay_one = 0;
                    delay_two = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[SAMPLE_WIDTH-1:0];
                if (expected_samples.size() == 0) begin
                    $error("sample_out transfer with no sample pending: got %0d", $signed(got));
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    samples_checked++;
                    if (got !== want) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(got));
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_samples.push_back(SAMPLE_WIDTH'(filter_sample(
                    longint'($signed(s_tdata[SAMPLE_WIDTH-1:0])))));
            end
        end
        outstanding = expected_samples.size();
    end

endmodule

/* dv/tb_biquad_iir_filter_top.sv */
`timescale 1ns / 1ps
// Testbench top for the biquad filter: clock, reset, stimulus and the final verdict.
module tb_biquad_iir_filter_top;

    localparam int SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH_DEF;
    localparam int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int IDX_BITS     = bqf_pkg::IDX_BITS;
    localparam int COEF_MAX     = 8388607;
    localparam int COEF_MIN     = -8388608;
    localparam int UNITY        = 1 << bqf_pkg::COEF_FRAC_BITS_DEF;
    localparam int RANDOM_BLOCKS    = 12;
    localparam int ITEMS_PER_BLOCK  = 138;
    localparam int CYCLE_LIMIT      = 400000;

    logic                              aclk;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // [15:0] sample_in
    logic [DATA_W-1:0]                 s_tdata  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // [15:0] sample_out
    logic [DATA_W-1:0]                 m_tdata;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [bqf_pkg::ADDR_BITS-1:0]     paddr    = '0;
    logic [bqf_pkg::APB_DATA_BITS-1:0] pwdata   = '0;
    logic [bqf_pkg::APB_DATA_BITS-1:0] prdata;
    logic                              pready;

    int mismatch_count;
    int outstanding;
    int samples_checked;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int coef_loads = 0;
    int cycle_count = 0;

    biquad_iir_filter_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    biquad_output_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .samples_checked (samples_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("biquad_iir_filter_top test failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_sample(input int x);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(SAMPLE_WIDTH'(x));
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {8'($urandom), 24'(value)};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_coefs(input int b0, input int b1, input int b2, input int a1,
                             input int a2);
        wait_drained();
        write_reg(bqf_pkg::REG_B0, b0);
        write_reg(bqf_pkg::REG_B1, b1);
        write_reg(bqf_pkg::REG_B2, b2);
        write_reg(bqf_pkg::REG_A1, a1);
        write_reg(bqf_pkg::REG_A2, a2);
        coef_loads++;
    endtask

    function automatic int pick_extreme_coef();
        case ($urandom_range(0, 4))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return 0;
            3: return UNITY;
            default: return -UNITY;
        endcase
    endfunction

    function automatic int rand_coef();
        return int'($urandom_range(0, (1 << 24) - 1)) - (1 << 23);
    endfunction

    function automatic int rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return int'($urandom_range(0, 65535)) - 32768;
        end else if (r < 80) begin
            case ($urandom_range(0, 4))
                0: return 32767;
                1: return -32768;
                2: return 0;
                3: return 1;
                default: return -1;
            endcase
        end
        return int'($urandom_range(0, 64)) - 32;
    endfunction

    task automatic load_random_coefs(input int kind);
        int a1;
        int a2;
        int bound;
        case (kind)
            0: set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
            1: begin
                // Keep the poles inside the unit circle so the output stays live.
                a2 = int'($urandom_range(0, 1800000)) - 900000;
                bound = UNITY + a2 - 20000;
                a1 = int'($urandom_range(0, 2 * bound)) - bound;
                set_coefs(int'($urandom_range(0, 2 * UNITY)) - UNITY,
                          int'($urandom_range(0, 2 * UNITY)) - UNITY,
                          int'($urandom_range(0, 2 * UNITY)) - UNITY, a1, a2);
            end
            2: set_coefs(pick_extreme_coef(), pick_extreme_coef(), pick_extreme_coef(),
                         pick_extreme_coef(), pick_extreme_coef());
            default: begin
                wait_drained();
                for (int r = 0; r < bqf_pkg::NUM_COEFS; r++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        write_reg(IDX_BITS'(r), rand_coef());
                    end
                end
                coef_loads++;
            end
        endcase
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset coefficients pass samples straight through.
        send_sample(0);
        send_sample(32767);
        send_sample(-32768);
        send_sample(1);
        send_sample(-1);
        send_sample(12345);

        // A gain of one half lands odd samples exactly on the rounding midpoint.
        set_coefs(UNITY / 2, 0, 0, 0, 0);
        send_sample(1);
        send_sample(-1);
        send_sample(3);
        send_sample(-3);
        send_sample(32767);
        send_sample(-32768);

        // Full-scale coefficients drive both the output and the delays into saturation.
        set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        send_sample(32767);
        send_sample(32767);
        send_sample(-32768);
        send_sample(-32768);
        send_sample(32767);

        set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_sample(-32768);
        send_sample(-32768);
        send_sample(32767);

        // A write past the last coefficient must leave the delay line intact.
        set_coefs(UNITY, UNITY, UNITY / 2, 0, 0);
        send_sample(1000);
        send_sample(2000);
        wait_drained();
        write_reg(IDX_BITS'(bqf_pkg::NUM_COEFS), rand_coef());
        send_sample(3000);
        send_sample(-4000);

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            wait_drained();
            case (blk % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            load_random_coefs((blk + blk / 4) % 4);
            for (int i = 0; i < ITEMS_PER_BLOCK; i++) begin
                if (i == ITEMS_PER_BLOCK / 2) begin
                    wait_drained();
                    if ($urandom_range(0, 1) == 1) begin
                        write_reg(IDX_BITS'($urandom_range(bqf_pkg::NUM_COEFS,
                                                           (1 << IDX_BITS) - 1)),
                                  rand_coef());
                    end
                end
                send_sample(rand_sample());
            end
        end

        wait_drained();
        repeat (20) @(negedge aclk);

        $display("Run covered %0d filtered samples over %0d coefficient loads,",
                 samples_checked, coef_loads);
        $display("with saturation, rounding, ignored writes and four idling mixes.");
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("biquad_iir_filter_top test passed");
        end else begin
            $display("biquad_iir_filter_top test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bqf_pkg.sv
hw/rtl/bqf_regs.sv
hw/rtl/bqf_ctrl.sv
hw/rtl/bqf_datapath.sv
hw/rtl/biquad_iir_filter_top.sv
dv/biquad_output_checker.sv
dv/tb_biquad_iir_filter_top.sv
